FILE: sv/cal_pkg.sv
// ----------------------------------------------------------------------------
// cal_pkg: shared definitions for the compacting array list
// Sizes, command and status codes, and the control bus broadcast to cells.
// ----------------------------------------------------------------------------
package cal_pkg;

  // list geometry
  localparam int DEPTH      = 64;
  localparam int ITEM_WIDTH = 32;

  // fixed field widths of the stream items
  localparam int CMD_W   = 2;
  localparam int IDX_W   = 6;
  localparam int VALUE_W = 32;
  localparam int STAT_W  = 2;
  localparam int CNTO_W  = 7;

  // derived widths
  localparam int POS_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (IDX_W > CNT_W) ? IDX_W : CNT_W;

  // packed stream widths, rounded up to whole bytes
  localparam int IN_BITS  = CMD_W + IDX_W + VALUE_W;
  localparam int OUT_BITS = VALUE_W + STAT_W + CNTO_W;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH = 2'd0,
    CMD_DEL  = 2'd1,
    CMD_READ = 2'd2,
    CMD_POP  = 2'd3
  } cal_cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } cal_status_t;

  // control broadcast from the list control to every cell
  typedef struct packed {
    logic                  push_en;
    logic [CMP_W-1:0]      wr_pos;
    logic [ITEM_WIDTH-1:0] wr_item;
    logic                  del_en;
    logic [CMP_W-1:0]      del_pos;
    logic [CMP_W-1:0]      rd_pos;
  } cal_bus_t;

endpackage

FILE: sv/cal_cell.sv
// ----------------------------------------------------------------------------
// cal_cell: one list entry
// Holds one item; loads on a push at its position, takes its upper neighbor
// on a delete at or below its position, and drives its item on a read match.
// ----------------------------------------------------------------------------
module cal_cell
  import cal_pkg::*;
(
  input  logic                  clk,
  input  logic [POS_W-1:0]      cell_pos,
  input  cal_bus_t              bus,
  input  logic [ITEM_WIDTH-1:0] nbr_data,
  output logic [ITEM_WIDTH-1:0] data_q,
  output logic [ITEM_WIDTH-1:0] rd_term
);

  logic [ITEM_WIDTH-1:0] data_r;
  logic [ITEM_WIDTH-1:0] data_nxt;
  logic [CMP_W-1:0]      pos_ext;
  logic                  load;
  logic                  shift;

  assign pos_ext = CMP_W'(cell_pos);
  assign load    = bus.push_en && (pos_ext == bus.wr_pos);
  assign shift   = bus.del_en && (pos_ext >= bus.del_pos);

  // entry update: append or compact down by one
  always_comb begin
    data_nxt = data_r;
    if (load) begin
      data_nxt = bus.wr_item;
    end else if (shift) begin
      data_nxt = nbr_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  // stored item handed to the neighbor below
  assign data_q = data_r;

  // read-out term, zero unless this cell is addressed
  assign rd_term = (pos_ext == bus.rd_pos) ? data_r : '0;

endmodule

FILE: sv/compacting_array_list.sv
// ----------------------------------------------------------------------------
// compacting_array_list: bounded ordered list with compacting delete
// Row of entry cells under a shared count and command decoder.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one command per transfer (push, delete at index, read at index,
//           pop last). tdata packs command, index and item value.
//   out_* : one result per command: read value, status and the new count.
//   The result is registered: a command taken at an edge has its result
//   on out_* from that edge on. One command is taken every cycle while
//   in_tready is high; all cells shift together on a delete, so no stall.
//   The read value comes from a position match in every cell, merged onto
//   a single read bus, which sets the length of the read path.
//   Errors (full on push, empty list, index past the end) give a status
//   code, a zero read value and leave the list as it was.
//   Reset clears the count and the result valid flag; cell contents are not
//   cleared and are only ever read below the count.
//   When the receiver stalls, the result is held in the output register
//   and in_tready drops until it is taken; with out_tready high, a new
//   command is taken in the same cycle the previous result leaves.
// ----------------------------------------------------------------------------
module compacting_array_list
  import cal_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [1:0] command, [7:2] index, [39:8] item_value
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [31:0] read_value, [33:32] status, [40:34] count_after, rest zero
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  // input field split
  cal_cmd_t             cmd;
  logic [IDX_W-1:0]     idx;
  logic [VALUE_W-1:0]   item_value;

  assign cmd        = cal_cmd_t'(in_tdata[CMD_W-1:0]);
  assign idx        = in_tdata[CMD_W +: IDX_W];
  assign item_value = in_tdata[CMD_W+IDX_W +: VALUE_W];

  logic                   in_fire;
  logic [CNT_W-1:0]       count_r;
  logic [CNT_W-1:0]       count_nxt;
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic [OUT_TDATA_W-1:0] out_data_nxt;

  logic                   empty;
  logic                   full;
  logic                   in_range;
  logic [CMP_W-1:0]       idx_ext;
  logic [CMP_W-1:0]       cnt_ext;
  cal_status_t            status;
  cal_bus_t               bus;
  logic [ITEM_WIDTH-1:0]  rd_merge;
  logic [VALUE_W-1:0]     rd_value;

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  // command checks against the current count
  assign idx_ext  = CMP_W'(idx);
  assign cnt_ext  = CMP_W'(count_r);
  assign empty    = (count_r == '0);
  assign full     = (count_r == CNT_W'(DEPTH));
  assign in_range = (idx_ext < cnt_ext);

  always_comb begin
    status = ST_OK;
    case (cmd)
      CMD_PUSH: begin
        if (full) status = ST_FULL;
      end
      CMD_DEL, CMD_READ: begin
        if (empty) begin
          status = ST_EMPTY;
        end else if (!in_range) begin
          status = ST_RANGE;
        end
      end
      CMD_POP: begin
        if (empty) status = ST_EMPTY;
      end
      default: status = ST_OK;
    endcase
  end

  // broadcast to the cell row
  always_comb begin
    bus.push_en = in_fire && (cmd == CMD_PUSH) && (status == ST_OK);
    bus.wr_pos  = cnt_ext;
    bus.wr_item = ITEM_WIDTH'(item_value);
    bus.del_en  = in_fire && (cmd == CMD_DEL) && (status == ST_OK);
    bus.del_pos = idx_ext;
    bus.rd_pos  = (cmd == CMD_POP) ? (cnt_ext - CMP_W'(1)) : idx_ext;
  end

  // cell row, each cell fed by its upper neighbor
  logic [ITEM_WIDTH-1:0] rd_terms [DEPTH];
  logic [ITEM_WIDTH-1:0] nbr      [DEPTH];
  logic [ITEM_WIDTH-1:0] cell_q   [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cal_cell u_cell (
      .clk      (clk),
      .cell_pos (POS_W'(i)),
      .bus      (bus),
      .nbr_data (nbr[i]),
      .data_q   (cell_q[i]),
      .rd_term  (rd_terms[i])
    );
  end

  // neighbor links: each cell sees the stored value above it, the top cell sees zero
  for (genvar i = 0; i < DEPTH; i++) begin : g_nbr
    if (i == DEPTH - 1) begin : g_top
      assign nbr[i] = '0;
    end else begin : g_mid
      assign nbr[i] = cell_q[i+1];
    end
  end

  // merge of the read terms, only the addressed cell is nonzero
  always_comb begin
    rd_merge = '0;
    for (int k = 0; k < DEPTH; k++) begin
      rd_merge = rd_merge | rd_terms[k];
    end
  end

  always_comb begin
    rd_value = '0;
    if (status == ST_OK && (cmd == CMD_READ || cmd == CMD_POP)) begin
      rd_value = VALUE_W'(rd_merge);
    end
  end

  // count update
  always_comb begin
    count_nxt = count_r;
    if (bus.push_en) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (bus.del_en || (in_fire && cmd == CMD_POP && status == ST_OK)) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  // result packing
  always_comb begin
    out_data_nxt = '0;
    out_data_nxt[VALUE_W-1:0]              = rd_value;
    out_data_nxt[VALUE_W +: STAT_W]        = status;
    out_data_nxt[VALUE_W+STAT_W +: CNTO_W] = CNTO_W'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("count beyond list depth");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && cmd == CMD_PUSH && !full |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("push did not grow the list");

  a_error_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && status != ST_OK |=> count_r == $past(count_r))
    else $error("rejected command changed the count");

  a_count_echo: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_tdata[VALUE_W+STAT_W +: CNTO_W] == CNTO_W'(count_r))
    else $error("reported count differs from held count");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[VALUE_W +: STAT_W] != ST_OK |-> out_tdata[VALUE_W-1:0] == '0)
    else $error("error result carries a value");

endmodule

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb: bench for the compacting array list
// Streams push, delete, read and pop commands into the list under random
// input gaps and output stalls. A shadow copy of the list predicts each
// result, and every result is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module tb;
  import cal_pkg::*;

  localparam int N_ITEMS = 1950;
  localparam int N_STEPS = 20;

  // one result as it appears on out_tdata, unpacked
  typedef struct packed {
    logic [VALUE_W-1:0] rd_value;
    cal_status_t        status;
    logic [CNTO_W-1:0]  count;
  } list_result_t;

  // one directed command, with a typed expectation where it is obvious
  typedef struct {
    cal_cmd_t           cmd;
    logic [IDX_W-1:0]   idx;
    logic [VALUE_W-1:0] value;
    bit                 typed;
    list_result_t       res;
  } step_row_t;

  typedef enum int {MODE_MIX, MODE_GROW, MODE_SHRINK, MODE_FILL, MODE_DRAIN} mode_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  // [1:0] command, [7:2] index, [39:8] item_value
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  // [31:0] read_value, [33:32] status, [40:34] count_after, rest zero
  logic [OUT_TDATA_W-1:0] out_tdata;

  // shadow list and the results still owed by the block
  logic [ITEM_WIDTH-1:0] shadow_list [DEPTH];
  int                    shadow_count;
  list_result_t          pending_results [$];

  step_row_t steps [N_STEPS];

  int errors;
  int checked;
  int sent;
  int peak_count;
  int cmd_tally [4];
  int status_tally [4];
  int gap_pct;
  int stall_pct;
  int stall_left;

  compacting_array_list uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  // apply one command to the shadow list and return the result it gives
  function automatic list_result_t predict_list_result(cal_cmd_t cmd, logic [IDX_W-1:0] idx,
                                                       logic [VALUE_W-1:0] value);
    list_result_t r;
    int k;
    r.rd_value = '0;
    r.status   = ST_OK;
    case (cmd)
      CMD_PUSH: begin
        if (shadow_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          shadow_list[shadow_count] = value[ITEM_WIDTH-1:0];
          shadow_count++;
        end
      end
      CMD_DEL: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else if (int'(idx) >= shadow_count) begin
          r.status = ST_RANGE;
        end else begin
          // close the gap: every later entry moves down one place
          for (k = int'(idx); k < shadow_count - 1; k++) shadow_list[k] = shadow_list[k + 1];
          shadow_count--;
        end
      end
      CMD_READ: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else if (int'(idx) >= shadow_count) begin
          r.status = ST_RANGE;
        end else begin
          r.rd_value = VALUE_W'(shadow_list[idx]);
        end
      end
      default: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          shadow_count--;
          r.rd_value = VALUE_W'(shadow_list[shadow_count]);
        end
      end
    endcase
    r.count = CNTO_W'(shadow_count);
    return r;
  endfunction

  // drive one command after an optional gap and log its expectation on transfer
  task automatic send_command(cal_cmd_t cmd, logic [IDX_W-1:0] idx, logic [VALUE_W-1:0] value,
                              bit typed, list_result_t typed_res);
    list_result_t pred;
    int gap;
    @(negedge clk);
    gap = 0;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) gap = $urandom_range(1, 12);
    if (gap != 0) begin
      in_tvalid = 1'b0;
      in_tdata  = IN_TDATA_W'({$urandom, $urandom});
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = IN_TDATA_W'({value, idx, cmd});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pred = predict_list_result(cmd, idx, value);
    pending_results.push_back(typed ? typed_res : pred);
    sent++;
    cmd_tally[cmd]++;
    status_tally[pred.status]++;
    if (shadow_count > peak_count) peak_count = shadow_count;
  endtask

  // hold the sender until every owed result has come back
  task automatic settle_results();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic note_mismatch(string field, logic [63:0] want, logic [63:0] got);
    errors++;
    if (errors <= 10)
      $display("tb: result %0d, %s: expected %0h, got %0h", checked, field, want, got);
  endtask

  // receiver: random stall bursts while stall_pct is nonzero
  always @(negedge clk) begin
    if (rst_n) begin
      if (stall_left > 0) begin
        out_tready = 1'b0;
        stall_left--;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        out_tready = 1'b0;
        stall_left = $urandom_range(1, 12) - 1;
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  // compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    list_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("tb: result with nothing expected: %0h", out_tdata);
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[VALUE_W-1:0] != want.rd_value)
          note_mismatch("read_value", 64'(want.rd_value), 64'(out_tdata[VALUE_W-1:0]));
        if (out_tdata[VALUE_W +: STAT_W] != want.status)
          note_mismatch("status", 64'(want.status), 64'(out_tdata[VALUE_W +: STAT_W]));
        if (out_tdata[VALUE_W + STAT_W +: CNTO_W] != want.count)
          note_mismatch("count_after", 64'(want.count), 64'(out_tdata[VALUE_W + STAT_W +: CNTO_W]));
        if (out_tdata[OUT_TDATA_W-1:OUT_BITS] != '0)
          note_mismatch("padding", 64'd0, 64'(out_tdata[OUT_TDATA_W-1:OUT_BITS]));
        checked++;
      end
    end
  end

  initial begin
    mode_t              mode;
    cal_cmd_t           cmd;
    logic [IDX_W-1:0]   idx;
    logic [VALUE_W-1:0] value;
    int                 seg_len;
    int                 next_settle;
    int                 r;

    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    out_tready   = 1'b0;
    shadow_count = 0;
    errors       = 0;
    checked      = 0;
    sent         = 0;
    peak_count   = 0;
    gap_pct      = 0;
    stall_pct    = 0;
    stall_left   = 0;
    foreach (cmd_tally[i]) cmd_tally[i] = 0;
    foreach (status_tally[i]) status_tally[i] = 0;

    // directed commands: empty list errors, extreme values, range errors,
    // delete that compacts, pops down to empty again
    steps = '{
      '{CMD_READ, 6'd0,  32'h0,         1'b1, '{32'h0,         ST_EMPTY, 7'd0}},
      '{CMD_DEL,  6'd0,  32'hffff_ffff, 1'b1, '{32'h0,         ST_EMPTY, 7'd0}},
      '{CMD_POP,  6'd63, 32'hffff_ffff, 1'b1, '{32'h0,         ST_EMPTY, 7'd0}},
      '{CMD_PUSH, 6'd63, 32'h0,         1'b1, '{32'h0,         ST_OK,    7'd1}},
      '{CMD_PUSH, 6'd0,  32'hffff_ffff, 1'b1, '{32'h0,         ST_OK,    7'd2}},
      '{CMD_PUSH, 6'd21, 32'h5a5a_a5a5, 1'b0, '{32'h0,         ST_OK,    7'd0}},
      '{CMD_PUSH, 6'd42, 32'h1234_5678, 1'b0, '{32'h0,         ST_OK,    7'd0}},
      '{CMD_READ, 6'd0,  32'hffff_ffff, 1'b1, '{32'h0,         ST_OK,    7'd4}},
      '{CMD_READ, 6'd1,  32'h0,         1'b1, '{32'hffff_ffff, ST_OK,    7'd4}},
      '{CMD_READ, 6'd4,  32'h0,         1'b1, '{32'h0,         ST_RANGE, 7'd4}},
      '{CMD_READ, 6'd63, 32'h0,         1'b1, '{32'h0,         ST_RANGE, 7'd4}},
      '{CMD_DEL,  6'd4,  32'h0,         1'b1, '{32'h0,         ST_RANGE, 7'd4}},
      '{CMD_DEL,  6'd63, 32'h0,         1'b1, '{32'h0,         ST_RANGE, 7'd4}},
      '{CMD_DEL,  6'd1,  32'hffff_ffff, 1'b0, '{32'h0,         ST_OK,    7'd0}},
      '{CMD_READ, 6'd1,  32'h0,         1'b0, '{32'h0,         ST_OK,    7'd0}},
      '{CMD_DEL,  6'd2,  32'h0,         1'b0, '{32'h0,         ST_OK,    7'd0}},
      '{CMD_POP,  6'd0,  32'h0,         1'b1, '{32'h5a5a_a5a5, ST_OK,    7'd1}},
      '{CMD_POP,  6'd63, 32'h0,         1'b1, '{32'h0,         ST_OK,    7'd0}},
      '{CMD_POP,  6'd0,  32'h0,         1'b1, '{32'h0,         ST_EMPTY, 7'd0}},
      '{CMD_READ, 6'd0,  32'h0,         1'b1, '{32'h0,         ST_EMPTY, 7'd0}}
    };

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (steps[i])
      send_command(steps[i].cmd, steps[i].idx, steps[i].value, steps[i].typed, steps[i].res);
    settle_results();

    // random segments, each with its own command mix and idle rates
    next_settle = 500;
    while (sent < N_ITEMS) begin
      if (sent >= N_ITEMS - 150) begin
        mode      = MODE_MIX;
        gap_pct   = 0;
        stall_pct = 0;
        seg_len   = N_ITEMS - sent;
      end else begin
        mode      = mode_t'($urandom_range(0, 4));
        r         = $urandom_range(0, 2);
        gap_pct   = (r == 0) ? 0 : (r == 1) ? 10 : 35;
        r         = $urandom_range(0, 2);
        stall_pct = (r == 0) ? 0 : (r == 1) ? 10 : 35;
        seg_len   = $urandom_range(40, 120);
        if (mode == MODE_FILL) seg_len = DEPTH - shadow_count + $urandom_range(1, 4);
        if (mode == MODE_DRAIN) seg_len = shadow_count + $urandom_range(1, 3);
        if (sent >= next_settle) begin
          settle_results();
          next_settle += 500;
        end
      end
      repeat (seg_len) begin
        r = $urandom_range(0, 99);
        case (mode)
          MODE_MIX:    cmd = (r < 35) ? CMD_PUSH : (r < 55) ? CMD_DEL :
                             (r < 85) ? CMD_READ : CMD_POP;
          MODE_GROW:   cmd = (r < 70) ? CMD_PUSH : (r < 85) ? CMD_READ :
                             (r < 93) ? CMD_DEL  : CMD_POP;
          MODE_SHRINK: cmd = (r < 20) ? CMD_PUSH : (r < 45) ? CMD_DEL :
                             (r < 65) ? CMD_READ : CMD_POP;
          MODE_FILL:   cmd = (r < 92) ? CMD_PUSH : CMD_READ;
          default:     cmd = (r < 50) ? CMD_POP  : (r < 85) ? CMD_DEL : CMD_READ;
        endcase
        // index mostly inside the list, sometimes at its end or anywhere
        r = $urandom_range(0, 9);
        if (shadow_count > 0 && r < 7) idx = IDX_W'($urandom_range(0, shadow_count - 1));
        else if (r == 7) idx = IDX_W'(shadow_count);
        else idx = IDX_W'($urandom);
        r = $urandom_range(0, 9);
        value = (r == 0) ? '0 : (r == 1) ? '1 : VALUE_W'($urandom);
        send_command(cmd, idx, value, 1'b0, '0);
      end
    end

    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("tb: %0d commands (push %0d, delete %0d, read %0d, pop %0d), %0d results compared",
             sent, cmd_tally[CMD_PUSH], cmd_tally[CMD_DEL], cmd_tally[CMD_READ],
             cmd_tally[CMD_POP], checked);
    $display("tb: status ok %0d, empty %0d, out of range %0d, full %0d; deepest list %0d",
             status_tally[ST_OK], status_tally[ST_EMPTY], status_tally[ST_RANGE],
             status_tally[ST_FULL], peak_count);
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: %0d mismatches", errors);
      $display("tb: done, errors");
    end
    $finish;
  end

  // watchdog far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("tb: timeout");
    $display("tb: done, errors");
    $finish;
  end

endmodule
